// ===== hdl/smcs_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and command codes of the switch matrix change scanner.
package smcs_pkg;

	localparam int FIFO_DEPTH     = 32;
	localparam int MATRIX_COLUMNS = 8;
	localparam int GROUPS         = 11;
	localparam int AUX_BASE       = 8;

	localparam int PTR_W   = $clog2(FIFO_DEPTH);
	localparam int CNT_W   = $clog2(FIFO_DEPTH + 1);
	localparam int PHASE_W = $clog2(2 * MATRIX_COLUMNS);
	localparam int GRP_W   = $clog2(GROUPS);

	localparam logic [7:0] NO_EVENT     = 8'd127;
	localparam logic [7:0] CLOSE_OFFSET = 8'd127;

	typedef enum logic [1:0] {
		CMD_SCAN = 2'd0,
		CMD_AUX  = 2'd1,
		CMD_POP  = 2'd2,
		CMD_SYNC = 2'd3
	} cmd_t;

	localparam logic [1:0] AUX_DIRECT = 2'd0;
	localparam logic [1:0] AUX_FLIP   = 2'd1;
	localparam logic [1:0] AUX_EXTRA  = 2'd2;

	localparam logic REG_FLIP  = 1'b0;
	localparam logic REG_EXTRA = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_in;
		logic exec;
		logic walk;
		logic load_out;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic walk_busy;
	} dp_stat_t;

endpackage

// ===== hdl/smcs_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencing state machine of the switch matrix change scanner.
module smcs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	output smcs_pkg::ctrl_cmd_t cmd,
	input  smcs_pkg::dp_stat_t  stat
);
	import smcs_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_WALK,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.load_in  = (state_q == ST_IDLE) && in_valid;
		cmd.exec     = (state_q == ST_EXEC);
		cmd.walk     = (state_q == ST_WALK);
		cmd.load_out = (state_q == ST_FINISH) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_FINISH) && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid)
						state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					state_q <= ST_WALK;
				end
				ST_WALK: begin
					if (!stat.walk_busy)
						state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hdl/smcs_datapath.sv =====
`timescale 1ns / 1ps
// Switch state, change walk, event queue, configuration registers and result register.
module smcs_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  smcs_pkg::ctrl_cmd_t cmd,
	output smcs_pkg::dp_stat_t  stat,
	input  logic [1:0]          command,
	input  logic [7:0]          pin_levels,
	input  logic [1:0]          aux_group,
	output logic [7:0]          column_drive,
	output logic [7:0]          event_code,
	output logic                event_valid,
	output logic [5:0]          pending_count,
	output logic                overflow,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata
);
	import smcs_pkg::*;

	// Latched item.
	logic [1:0]         command_q;
	logic [7:0]         sample_q;
	logic [1:0]         aux_q;

	// Switch state and scan.
	logic [7:0]         cur_q [GROUPS];
	logic [7:0]         rep_q [GROUPS];
	logic [PHASE_W-1:0] phase_q;
	logic [7:0]         column_q;

	// Change walk.
	logic               walk_busy_q;
	logic [GRP_W-1:0]   walk_grp_q;
	logic [GRP_W-1:0]   walk_last_q;

	// Event queue.
	logic [7:0]         fifo_mem [FIFO_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               overflow_q;
	logic [7:0]         rd_data_q;
	logic               pop_hit_q;

	// Configuration.
	logic               flip_en_q;
	logic               extra_en_q;

	// Result register.
	logic [7:0]         column_out_q;
	logic [7:0]         code_out_q;
	logic               hit_out_q;
	logic [5:0]         count_out_q;
	logic               overflow_out_q;

	logic [GRP_W-1:0]   scan_col;
	logic [GRP_W-1:0]   aux_grp;
	logic               aux_ok;
	logic [7:0]         diff;
	logic [2:0]         low_bit;
	logic [7:0]         walk_code;
	logic               cur_bit;
	logic               fifo_full;
	logic               do_push;
	logic               cfg_write;

	function automatic logic [2:0] lowest_bit(input logic [7:0] v);
		logic [2:0] b;
		b = 3'd0;
		for (int i = 7; i >= 0; i--) begin
			if (v[i])
				b = 3'(i);
		end
		return b;
	endfunction

	always_comb begin
		scan_col = GRP_W'(phase_q >> 1);
		if (scan_col > GRP_W'(MATRIX_COLUMNS - 1))
			scan_col = GRP_W'(MATRIX_COLUMNS - 1);
	end

	assign aux_grp = GRP_W'(AUX_BASE) + GRP_W'(aux_q);
	assign aux_ok  = (aux_q == AUX_DIRECT) ||
	                 ((aux_q == AUX_FLIP) && flip_en_q) ||
	                 ((aux_q == AUX_EXTRA) && extra_en_q);

	assign diff      = cur_q[walk_grp_q] ^ rep_q[walk_grp_q];
	assign low_bit   = lowest_bit(diff);
	assign cur_bit   = cur_q[walk_grp_q][low_bit];
	assign walk_code = 8'({walk_grp_q, low_bit}) + 8'd1 + (cur_bit ? CLOSE_OFFSET : 8'd0);
	assign fifo_full = (count_q == CNT_W'(FIFO_DEPTH));
	assign do_push   = cmd.walk && walk_busy_q && (diff != 8'd0) && !fifo_full;

	assign stat.walk_busy = walk_busy_q;

	assign cfg_write = psel && penable && pwrite;
	assign prdata    = (paddr[2] == REG_EXTRA) ? {31'd0, extra_en_q} : {31'd0, flip_en_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flip_en_q  <= 1'b0;
			extra_en_q <= 1'b0;
		end else if (cfg_write) begin
			if (paddr[2] == REG_EXTRA)
				extra_en_q <= pwdata[0];
			else
				flip_en_q <= pwdata[0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			command_q <= command;
			sample_q  <= ~pin_levels;
			aux_q     <= aux_group;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int g = 0; g < GROUPS; g++) begin
				cur_q[g] <= 8'd0;
				rep_q[g] <= 8'd0;
			end
			phase_q     <= '0;
			column_q    <= 8'd0;
			walk_busy_q <= 1'b0;
			walk_grp_q  <= '0;
			walk_last_q <= '0;
			wr_ptr_q    <= '0;
			rd_ptr_q    <= '0;
			count_q     <= '0;
			overflow_q  <= 1'b0;
			pop_hit_q   <= 1'b0;
		end else begin
			if (cmd.exec) begin
				pop_hit_q <= (cmd_t'(command_q) == CMD_POP) && (count_q != '0);
				unique case (cmd_t'(command_q))
					CMD_SCAN: begin
						if (!phase_q[0]) begin
							column_q <= 8'd1 << scan_col;
						end else begin
							cur_q[scan_col] <= sample_q;
							column_q        <= 8'd0;
						end
						if (phase_q == PHASE_W'(2 * MATRIX_COLUMNS - 1)) begin
							phase_q     <= '0;
							walk_busy_q <= 1'b1;
							walk_grp_q  <= '0;
							walk_last_q <= GRP_W'(MATRIX_COLUMNS - 1);
						end else begin
							phase_q <= phase_q + 1'b1;
						end
					end
					CMD_AUX: begin
						if (aux_ok) begin
							cur_q[aux_grp] <= sample_q;
							walk_busy_q    <= 1'b1;
							walk_grp_q     <= aux_grp;
							walk_last_q    <= aux_grp;
						end
					end
					CMD_POP: begin
						if (count_q != '0) begin
							rd_ptr_q  <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ?
							             '0 : rd_ptr_q + 1'b1;
							count_q   <= count_q - 1'b1;
						end
					end
					CMD_SYNC: begin
						for (int g = 0; g < GROUPS; g++)
							rep_q[g] <= cur_q[g];
					end
					default: begin
					end
				endcase
			end

			// One changed bit, or one settled group, per walk cycle.
			if (cmd.walk && walk_busy_q) begin
				if (diff == 8'd0) begin
					if (walk_grp_q == walk_last_q)
						walk_busy_q <= 1'b0;
					else
						walk_grp_q <= walk_grp_q + 1'b1;
				end else begin
					rep_q[walk_grp_q][low_bit] <= cur_bit;
					if (fifo_full) begin
						overflow_q <= 1'b1;
					end else begin
						wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ?
						            '0 : wr_ptr_q + 1'b1;
						count_q  <= count_q + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			fifo_mem[wr_ptr_q] <= walk_code;
		if (cmd.exec && (cmd_t'(command_q) == CMD_POP))
			rd_data_q <= fifo_mem[rd_ptr_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			column_out_q   <= column_q;
			code_out_q     <= pop_hit_q ? rd_data_q : NO_EVENT;
			hit_out_q      <= pop_hit_q;
			count_out_q    <= 6'(count_q);
			overflow_out_q <= overflow_q;
		end
	end

	assign column_drive  = column_out_q;
	assign event_code    = code_out_q;
	assign event_valid   = hit_out_q;
	assign pending_count = count_out_q;
	assign overflow      = overflow_out_q;

endmodule

// ===== hdl/switch_matrix_change_scanner.sv =====
`timescale 1ns / 1ps
// Items are taken one at a time; input stays stalled until the last result is registered.
// A scan-ending tick or an enabled auxiliary sample also runs the change walk, which inspects
// each group in turn and handles one changed bit, or one settled group, per cycle.
// Reset: arst_n clears switch state, queue pointers, overflow, scan phase and enables;
// queue contents are not cleared.
module switch_matrix_change_scanner (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [7:0]  pin_levels,
	input  logic [1:0]  aux_group,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  column_drive,
	output logic [7:0]  event_code,
	output logic        event_valid,
	output logic [5:0]  pending_count,
	output logic        overflow,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import smcs_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	assign pready = 1'b1;

	smcs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	smcs_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.command       (command),
		.pin_levels    (pin_levels),
		.aux_group     (aux_group),
		.column_drive  (column_drive),
		.event_code    (event_code),
		.event_valid   (event_valid),
		.pending_count (pending_count),
		.overflow      (overflow),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata)
	);

endmodule

// ===== hdl/smcs_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks of the switch matrix change scanner and their binding.
module smcs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] column_drive,
	input logic [7:0] event_code,
	input logic       event_valid,
	input logic [5:0] pending_count
);
	import smcs_pkg::*;

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(event_code) &&
		$stable(pending_count) && $stable(column_drive))
		else $error("stalled result changed");

	// Items are taken one at a time: the cycle after a transfer in is stalled.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while an item is in progress");

	a_no_event_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !event_valid |-> event_code == NO_EVENT)
		else $error("event code shown without a popped event");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(pending_count) <= FIFO_DEPTH)
		else $error("pending count beyond queue depth");

	a_column_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot0(column_drive))
		else $error("more than one column driven");

endmodule

bind switch_matrix_change_scanner smcs_checker u_smcs_checker (.*);

// ===== sim/switch_matrix_change_scanner_chk.sv =====
`timescale 1ns / 1ps
// Transfer monitor, scanner state predictor and result comparator for the change scanner.
module switch_matrix_change_scanner_chk
	import smcs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  command,
	input  logic [7:0]  pin_levels,
	input  logic [1:0]  aux_group,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [7:0]  column_drive,
	input  logic [7:0]  event_code,
	input  logic        event_valid,
	input  logic [5:0]  pending_count,
	input  logic        overflow,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          mismatches,
	output int          awaited
);

	typedef struct {
		logic [7:0] column;
		logic [7:0] code;
		logic       popped;
		logic [5:0] count;
		logic       dropped;
	} scan_report_t;

	logic [7:0]         live_groups [GROUPS];
	logic [7:0]         known_groups [GROUPS];
	logic [7:0]         change_codes [$];
	logic [PHASE_W-1:0] tick;
	logic [7:0]         column_reg;
	logic               dropped_flag;
	logic               flip_en;
	logic               extra_en;
	scan_report_t       due_reports [$];

	task automatic queue_code(input logic [7:0] code);
		if (change_codes.size() >= FIFO_DEPTH)
			dropped_flag = 1'b1;
		else
			change_codes.push_back(code);
	endtask

	// Walking the bits upwards and copying only the reported bit gives the same order
	// as repeatedly taking the lowest differing bit.
	task automatic walk_group(input int g);
		logic [7:0] code;
		for (int b = 0; b < 8; b++) begin
			if (live_groups[g][b] != known_groups[g][b]) begin
				code = 8'(g * 8 + b + 1);
				if (live_groups[g][b])
					code = code + CLOSE_OFFSET;
				known_groups[g][b] = live_groups[g][b];
				queue_code(code);
			end
		end
	endtask

	task automatic advance_scanner(input cmd_t cmd, input logic [7:0] pins,
			input logic [1:0] aux);
		scan_report_t rep;
		logic [7:0]   closed;
		logic [2:0]   col;
		closed     = ~pins;
		rep.code   = NO_EVENT;
		rep.popped = 1'b0;
		case (cmd)
			CMD_SCAN: begin
				col = tick[PHASE_W-1:1];
				if (!tick[0]) begin
					column_reg = 8'd1 << col;
				end else begin
					live_groups[col] = closed;
					column_reg       = 8'd0;
				end
				if (tick == PHASE_W'(2 * MATRIX_COLUMNS - 1)) begin
					tick = '0;
					for (int g = 0; g < MATRIX_COLUMNS; g++)
						walk_group(g);
				end else begin
					tick = tick + 1'b1;
				end
			end
			CMD_AUX: begin
				if (aux == AUX_DIRECT || (aux == AUX_FLIP && flip_en) ||
						(aux == AUX_EXTRA && extra_en)) begin
					live_groups[AUX_BASE + aux] = closed;
					walk_group(AUX_BASE + aux);
				end
			end
			CMD_POP: begin
				if (change_codes.size() > 0) begin
					rep.code   = change_codes.pop_front();
					rep.popped = 1'b1;
				end
			end
			CMD_SYNC: begin
				for (int g = 0; g < GROUPS; g++)
					known_groups[g] = live_groups[g];
			end
		endcase
		rep.column  = column_reg;
		rep.count   = 6'(change_codes.size());
		rep.dropped = dropped_flag;
		due_reports.push_back(rep);
	endtask

	always @(posedge clk or negedge arst_n) begin
		scan_report_t want;
		if (!arst_n) begin
			for (int g = 0; g < GROUPS; g++) begin
				live_groups[g]  = 8'd0;
				known_groups[g] = 8'd0;
			end
			change_codes.delete();
			due_reports.delete();
			tick         = '0;
			column_reg   = 8'd0;
			dropped_flag = 1'b0;
			flip_en      = 1'b0;
			extra_en     = 1'b0;
			mismatches   = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (due_reports.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result transfer with none expected: col %h code %0d valid %b count %0d ovf %b",
							$realtime, column_drive, event_code, event_valid,
							pending_count, overflow);
				end else begin
					want = due_reports.pop_front();
					if (column_drive !== want.column || event_code !== want.code ||
							event_valid !== want.popped || pending_count !== want.count ||
							overflow !== want.dropped) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: expected col %h code %0d valid %b count %0d ovf %b, got col %h code %0d valid %b count %0d ovf %b",
								$realtime, want.column, want.code, want.popped,
								want.count, want.dropped, column_drive, event_code,
								event_valid, pending_count, overflow);
					end
				end
			end
			if (in_valid && !in_stall)
				advance_scanner(cmd_t'(command), pin_levels, aux_group);
			if (psel && penable && pwrite && pready) begin
				if (paddr == {REG_FLIP, 2'b00})
					flip_en = pwdata[0];
				else if (paddr == {REG_EXTRA, 2'b00})
					extra_en = pwdata[0];
			end
		end
		awaited = due_reports.size();
	end

endmodule

// ===== sim/switch_matrix_change_scanner_tb.sv =====
`timescale 1ns / 1ps
// Stimulus, configuration sequencing and verdict for the switch matrix change scanner.
module switch_matrix_change_scanner_tb;
	import smcs_pkg::*;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 170;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        in_valid   = 1'b0;
	logic        in_stall;
	logic [1:0]  command    = CMD_POP;
	logic [7:0]  pin_levels = 8'hFF;
	logic [1:0]  aux_group  = AUX_DIRECT;
	logic        out_valid;
	logic        out_stall  = 1'b0;
	logic [7:0]  column_drive;
	logic [7:0]  event_code;
	logic        event_valid;
	logic [5:0]  pending_count;
	logic        overflow;
	logic        psel       = 1'b0;
	logic        penable    = 1'b0;
	logic        pwrite     = 1'b0;
	logic [2:0]  paddr      = 3'd0;
	logic [31:0] pwdata     = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	int          mismatches;
	int          awaited;
	int          cycles        = 0;
	int          send_idle_pct = 0;
	int          stall_pct     = 0;

	logic [7:0]  held_rows [MATRIX_COLUMNS];
	logic [7:0]  held_aux [4];
	logic [3:0]  sent_ticks = 4'd0;

	always #10 clk = ~clk;

	switch_matrix_change_scanner DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.pin_levels   (pin_levels),
		.aux_group    (aux_group),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.column_drive (column_drive),
		.event_code   (event_code),
		.event_valid  (event_valid),
		.pending_count(pending_count),
		.overflow     (overflow),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	switch_matrix_change_scanner_chk checker_inst (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.pin_levels   (pin_levels),
		.aux_group    (aux_group),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.column_drive (column_drive),
		.event_code   (event_code),
		.event_valid  (event_valid),
		.pending_count(pending_count),
		.overflow     (overflow),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.pready       (pready),
		.mismatches   (mismatches),
		.awaited      (awaited)
	);

	always @(negedge clk)
		out_stall <= ($urandom_range(99) < stall_pct);

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Valid stays high from one transfer to the next unless an idle cycle is rolled.
	task automatic send_item(input cmd_t cmd, input logic [7:0] pins, input logic [1:0] aux);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid   = 1'b1;
		command    = cmd;
		pin_levels = pins;
		aux_group  = aux;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (cmd == CMD_SCAN)
			sent_ticks = sent_ticks + 1'b1;
	endtask

	// Every item yields exactly one result, so an empty expectation queue means idle.
	task automatic quiesce(input int settle);
		@(negedge clk);
		in_valid = 1'b0;
		while (awaited != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_reg(input logic index, input logic value);
		@(negedge clk);
		psel    = 1'b1;
		pwrite  = 1'b1;
		penable = 1'b0;
		paddr   = {index, 2'b00};
		pwdata  = {31'd0, value};
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	function automatic logic [7:0] wobble(input logic [7:0] pins);
		int roll;
		roll = $urandom_range(99);
		if (roll < 4)
			return 8'($urandom);
		else if (roll < 30)
			return pins ^ (8'd1 << $urandom_range(7));
		return pins;
	endfunction

	task automatic random_item();
		int         roll;
		logic [1:0] grp;
		logic [2:0] col;
		roll = $urandom_range(99);
		if (roll < 55) begin
			col = sent_ticks[3:1];
			held_rows[col] = wobble(held_rows[col]);
			send_item(CMD_SCAN, held_rows[col], 2'($urandom));
		end else if (roll < 82) begin
			send_item(CMD_POP, 8'($urandom), 2'($urandom));
		end else if (roll < 84) begin
			// A burst of pops lets the queue drain and run empty.
			repeat (10) send_item(CMD_POP, 8'($urandom), 2'($urandom));
		end else if (roll < 96) begin
			grp = 2'($urandom);
			held_aux[grp] = wobble(held_aux[grp]);
			send_item(CMD_AUX, held_aux[grp], grp);
		end else begin
			send_item(CMD_SYNC, 8'($urandom), 2'($urandom));
		end
	endtask

	initial begin
		for (int c = 0; c < MATRIX_COLUMNS; c++)
			held_rows[c] = 8'hFF;
		for (int g = 0; g < 4; g++)
			held_aux[g] = 8'hFF;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// Directed part, enables still at their reset value of zero.
		send_item(CMD_POP, 8'h00, AUX_DIRECT);
		send_item(CMD_AUX, 8'hFE, AUX_DIRECT);
		send_item(CMD_AUX, 8'h00, AUX_FLIP);
		send_item(CMD_AUX, 8'h00, 2'd3);
		send_item(CMD_AUX, 8'h00, AUX_DIRECT);
		send_item(CMD_SYNC, 8'h00, AUX_DIRECT);
		send_item(CMD_POP, 8'hFF, AUX_EXTRA);
		quiesce(8);
		write_reg(REG_FLIP, 1'b1);
		write_reg(REG_EXTRA, 1'b1);
		send_item(CMD_AUX, 8'h00, AUX_FLIP);
		send_item(CMD_AUX, 8'h7F, AUX_EXTRA);
		send_item(CMD_AUX, 8'hFF, AUX_EXTRA);
		// A full scan with every switch closed fills the queue and drops the rest.
		repeat (2 * MATRIX_COLUMNS) send_item(CMD_SCAN, 8'h00, AUX_DIRECT);
		for (int c = 0; c < MATRIX_COLUMNS; c++)
			held_rows[c] = 8'h00;
		held_aux[AUX_DIRECT] = 8'h00;
		held_aux[AUX_FLIP]   = 8'h00;
		held_aux[AUX_EXTRA]  = 8'hFF;

		for (int p = 0; p < PHASES; p++) begin
			quiesce(8);
			write_reg(REG_FLIP, p[0]);
			write_reg(REG_EXTRA, p[1]);
			case (p >> 1)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 85; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 85; end
				default: begin send_idle_pct = 37; stall_pct = 37; end
			endcase
			repeat (PHASE_ITEMS) random_item();
		end

		quiesce(100);
		if (mismatches == 0 && awaited == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
